/* hdl/ffca_pkg.sv */
// ffca_pkg: types and constants shared by the first-fit allocator modules
// no dependencies
package ffca_pkg;

  localparam int WORDS       = 4096;
  localparam int ADDR_W      = 12;
  localparam int LEN_W       = 13;
  localparam int MAX_EXTENTS = 512;
  localparam int IDX_W       = 9;
  localparam int CNT_W       = 10;
  localparam int NODE_WORDS  = 4;
  localparam int BYTES_W     = 20;
  localparam int REQ_W       = 18;
  localparam int HI_W        = 14;

  typedef struct packed {
    logic [ADDR_W-1:0]  old_address;
    logic [BYTES_W-1:0] size_bytes;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] new_address;
    logic              alloc_failed;
    logic [CNT_W-1:0]  fragment_count;
  } out_item_t;

  typedef struct packed {
    logic [LEN_W-1:0] start;
    logic [LEN_W-1:0] stop;
  } extent_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    extent_t          wdata;
    logic [IDX_W-1:0] raddr;
  } ext_req_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [LEN_W-1:0]  wdata;
    logic [ADDR_W-1:0] raddr;
  } hdr_req_t;

endpackage

/* hdl/ffca_ram.sv */
// ffca_ram: simple dual-port synchronous ram, one write and one registered read
// no dependencies
module ffca_ram #(
  parameter int AW = 9,
  parameter int DW = 26
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/ffca_seq.sv */
// ffca_seq: request sequencer, scans and edits the extent table and header store
// depends on ffca_pkg
module ffca_seq (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  ffca_pkg::in_item_t       in_data,
  input  logic                     cfg_valid,
  input  logic [ffca_pkg::LEN_W-1:0] cfg_data,
  output logic                     idle,
  output logic                     res_valid,
  output ffca_pkg::out_item_t      res,
  input  logic                     res_ready,
  output ffca_pkg::ext_req_t       ext_req,
  input  ffca_pkg::extent_t        ext_rdata,
  output ffca_pkg::hdr_req_t       hdr_req,
  input  logic [ffca_pkg::LEN_W-1:0] hdr_rdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_HDR, S_FSCAN, S_FDECIDE, S_RM_RD, S_RM_WR, S_INS_RD, S_INS_WR,
    S_ASTART, S_ASCAN, S_ATAKE, S_DONE
  } state_t;

  state_t                          state_r;
  logic [ffca_pkg::ADDR_W-1:0]     old_r;
  logic [ffca_pkg::REQ_W-1:0]      w_r;
  logic [ffca_pkg::REQ_W-1:0]      need_r;
  logic [ffca_pkg::LEN_W-1:0]      addr_r;
  logic                            failed_r;
  logic                            do_alloc_r;
  logic                            in_alloc_r;
  logic [ffca_pkg::CNT_W-1:0]      count_r;
  logic [ffca_pkg::LEN_W-1:0]      region_r;
  logic [ffca_pkg::ADDR_W-1:0]     lo_r;
  logic [ffca_pkg::HI_W-1:0]       hi_r;
  logic [ffca_pkg::CNT_W-1:0]      idx_r;
  logic [ffca_pkg::CNT_W-1:0]      k_r;
  ffca_pkg::extent_t               prev_r;
  ffca_pkg::extent_t               cur_r;

  logic [ffca_pkg::REQ_W-1:0]      in_w;
  logic [ffca_pkg::LEN_W-1:0]      cfg_words;
  logic [ffca_pkg::ADDR_W-1:0]     lo_w;
  logic [ffca_pkg::HI_W-1:0]       free_hi;
  logic [ffca_pkg::REQ_W-1:0]      wmin;
  logic [ffca_pkg::REQ_W-1:0]      a_need;
  logic [ffca_pkg::LEN_W-1:0]      span;
  logic                            fits;
  logic                            split;
  logic                            has_prev;
  logic                            overlap;
  logic                            left;
  logic                            right;
  logic                            resize_same;
  logic                            last_idx;
  state_t                          fin_state;

  always_comb begin
    in_w = {1'b0, in_data.size_bytes[ffca_pkg::BYTES_W-1:3]}
         + ffca_pkg::REQ_W'(|in_data.size_bytes[2:0]);
    cfg_words = (cfg_data > ffca_pkg::LEN_W'(ffca_pkg::WORDS)) ?
                ffca_pkg::LEN_W'(ffca_pkg::WORDS) : cfg_data;
    lo_w = old_r - 1'b1;
    free_hi = ffca_pkg::HI_W'(lo_w) + ffca_pkg::HI_W'(hdr_rdata);
    resize_same = do_alloc_r && (hdr_rdata != '0) &&
                  (w_r == ffca_pkg::REQ_W'(hdr_rdata - 1'b1));
    wmin = (w_r < ffca_pkg::REQ_W'(ffca_pkg::NODE_WORDS - 1)) ?
           ffca_pkg::REQ_W'(ffca_pkg::NODE_WORDS - 1) : w_r;
    a_need = wmin + 1'b1;
    fits = (ext_rdata.stop >= ext_rdata.start) &&
           (ffca_pkg::REQ_W'(ext_rdata.stop - ext_rdata.start) >= need_r);
    span = cur_r.stop - cur_r.start;
    split = (ffca_pkg::REQ_W'(span) - need_r) >= ffca_pkg::REQ_W'(ffca_pkg::NODE_WORDS);
    has_prev = (idx_r != '0);
    overlap = has_prev && ({1'b0, lo_r} < prev_r.stop);
    left = has_prev && (prev_r.stop == {1'b0, lo_r});
    right = (idx_r < count_r) && ({1'b0, cur_r.start} == hi_r);
    last_idx = ((idx_r + 1'b1) == count_r);
    fin_state = do_alloc_r ? S_ASTART : S_DONE;
  end

  // memory requests
  always_comb begin
    ext_req = '0;
    hdr_req = '0;
    hdr_req.raddr = in_data.old_address - 1'b1;
    unique case (state_r)
      S_FSCAN, S_ASCAN: ext_req.raddr = ffca_pkg::IDX_W'(idx_r + 1'b1);
      S_RM_RD: ext_req.raddr = ffca_pkg::IDX_W'(k_r + 1'b1);
      S_INS_RD: ext_req.raddr = ffca_pkg::IDX_W'(k_r - 1'b1);
      default: ext_req.raddr = '0;
    endcase
    unique case (state_r)
      S_IDLE: begin
        if (cfg_valid) begin
          ext_req.we = 1'b1;
          ext_req.wdata.start = '0;
          ext_req.wdata.stop = cfg_words;
        end
      end
      S_FDECIDE: begin
        if (!overlap && left) begin
          ext_req.we = 1'b1;
          ext_req.waddr = ffca_pkg::IDX_W'(idx_r - 1'b1);
          ext_req.wdata.start = prev_r.start;
          ext_req.wdata.stop = right ? cur_r.stop : ffca_pkg::LEN_W'(hi_r);
        end else if (!overlap && right) begin
          ext_req.we = 1'b1;
          ext_req.waddr = ffca_pkg::IDX_W'(idx_r);
          ext_req.wdata.start = {1'b0, lo_r};
          ext_req.wdata.stop = cur_r.stop;
        end
      end
      S_RM_WR, S_INS_WR: begin
        ext_req.we = 1'b1;
        ext_req.waddr = ffca_pkg::IDX_W'(k_r);
        ext_req.wdata = ext_rdata;
      end
      S_INS_RD: begin
        if (k_r <= idx_r) begin
          ext_req.we = 1'b1;
          ext_req.waddr = ffca_pkg::IDX_W'(idx_r);
          ext_req.wdata.start = {1'b0, lo_r};
          ext_req.wdata.stop = ffca_pkg::LEN_W'(hi_r);
        end
      end
      S_ATAKE: begin
        if (cur_r.start < ffca_pkg::LEN_W'(ffca_pkg::WORDS)) begin
          hdr_req.we = 1'b1;
          hdr_req.waddr = ffca_pkg::ADDR_W'(cur_r.start);
          hdr_req.wdata = split ? ffca_pkg::LEN_W'(need_r) : span;
          if (split) begin
            ext_req.we = 1'b1;
            ext_req.waddr = ffca_pkg::IDX_W'(idx_r);
            ext_req.wdata.start = cur_r.start + ffca_pkg::LEN_W'(need_r);
            ext_req.wdata.stop = cur_r.stop;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      region_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (cfg_valid) begin
            region_r <= cfg_words;
            count_r  <= (cfg_words != '0) ? ffca_pkg::CNT_W'(1) : '0;
          end else if (in_valid) begin
            old_r      <= in_data.old_address;
            w_r        <= in_w;
            addr_r     <= '0;
            failed_r   <= 1'b0;
            do_alloc_r <= 1'b0;
            in_alloc_r <= 1'b0;
            if (in_w == '0) begin
              state_r <= (in_data.old_address == '0) ? S_DONE : S_HDR;
            end else if (in_data.old_address == '0) begin
              state_r <= S_ASTART;
            end else begin
              do_alloc_r <= 1'b1;
              state_r    <= S_HDR;
            end
          end
        end
        S_HDR: begin
          lo_r  <= lo_w;
          hi_r  <= free_hi;
          idx_r <= '0;
          if (resize_same) begin
            addr_r  <= ffca_pkg::LEN_W'(old_r);
            state_r <= S_DONE;
          end else if (hdr_rdata == '0 || free_hi > ffca_pkg::HI_W'(region_r)) begin
            state_r <= fin_state;
          end else begin
            state_r <= (count_r == '0) ? S_FDECIDE : S_FSCAN;
          end
        end
        S_FSCAN: begin
          if (hi_r <= ffca_pkg::HI_W'(ext_rdata.start)) begin
            cur_r   <= ext_rdata;
            state_r <= S_FDECIDE;
          end else if (hi_r <= ffca_pkg::HI_W'(ext_rdata.stop)) begin
            state_r <= fin_state;
          end else begin
            prev_r <= ext_rdata;
            idx_r  <= idx_r + 1'b1;
            if (last_idx) begin
              state_r <= S_FDECIDE;
            end
          end
        end
        S_FDECIDE: begin
          priority if (overlap) begin
            state_r <= fin_state;
          end else if (left && right) begin
            k_r        <= idx_r;
            in_alloc_r <= 1'b0;
            state_r    <= S_RM_RD;
          end else if (left || right) begin
            state_r <= fin_state;
          end else if (count_r >= ffca_pkg::CNT_W'(ffca_pkg::MAX_EXTENTS)) begin
            state_r <= fin_state;
          end else begin
            k_r     <= count_r;
            state_r <= S_INS_RD;
          end
        end
        S_RM_RD: begin
          if ((k_r + 1'b1) < count_r) begin
            state_r <= S_RM_WR;
          end else begin
            count_r <= count_r - 1'b1;
            state_r <= in_alloc_r ? S_DONE : fin_state;
          end
        end
        S_RM_WR: begin
          k_r     <= k_r + 1'b1;
          state_r <= S_RM_RD;
        end
        S_INS_RD: begin
          if (k_r > idx_r) begin
            state_r <= S_INS_WR;
          end else begin
            count_r <= count_r + 1'b1;
            state_r <= fin_state;
          end
        end
        S_INS_WR: begin
          k_r     <= k_r - 1'b1;
          state_r <= S_INS_RD;
        end
        S_ASTART: begin
          need_r <= a_need;
          idx_r  <= '0;
          if (count_r == '0) begin
            failed_r <= 1'b1;
            state_r  <= S_DONE;
          end else begin
            state_r <= S_ASCAN;
          end
        end
        S_ASCAN: begin
          if (fits) begin
            cur_r   <= ext_rdata;
            state_r <= S_ATAKE;
          end else if (last_idx) begin
            failed_r <= 1'b1;
            state_r  <= S_DONE;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_ATAKE: begin
          if (cur_r.start >= ffca_pkg::LEN_W'(ffca_pkg::WORDS)) begin
            failed_r <= 1'b1;
            state_r  <= S_DONE;
          end else begin
            addr_r <= cur_r.start + 1'b1;
            if (split) begin
              state_r <= S_DONE;
            end else begin
              k_r        <= idx_r;
              in_alloc_r <= 1'b1;
              state_r    <= S_RM_RD;
            end
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign idle = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res.new_address = addr_r[ffca_pkg::ADDR_W-1:0];
  assign res.alloc_failed = failed_r;
  assign res.fragment_count = count_r;

endmodule

/* hdl/first_fit_coalescing_allocator_core.sv */
// first-fit allocator core: one request at a time; the time from input transfer to result
// valid grows with every extent scanned and every extent shifted, as the extent ram has a
// single read port; the next request is taken only after the result has moved to the
// output register
// synchronous active-low reset clears control state, count and region size; rams are not cleared
module first_fit_coalescing_allocator_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  ffca_pkg::in_item_t         in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output ffca_pkg::out_item_t        out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [ffca_pkg::LEN_W-1:0] cfg_data
);

  logic                          idle;
  logic                          res_valid;
  ffca_pkg::out_item_t           res;
  logic                          res_ready;
  ffca_pkg::ext_req_t            ext_req;
  ffca_pkg::extent_t             ext_rdata;
  ffca_pkg::hdr_req_t            hdr_req;
  logic [ffca_pkg::LEN_W-1:0]    hdr_rdata;
  logic                          out_valid_r;
  ffca_pkg::out_item_t           out_data_r;

  // config write wins over a request in the same cycle
  assign in_stall  = !idle || cfg_valid;
  assign cfg_ready = idle;

  // result register frees the sequencer from output backpressure
  assign res_ready = !out_valid_r || !out_stall;

  ffca_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .idle      (idle),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .ext_req   (ext_req),
    .ext_rdata (ext_rdata),
    .hdr_req   (hdr_req),
    .hdr_rdata (hdr_rdata)
  );

  // address-ordered free extent table, start and stop in one word
  ffca_ram #(
    .AW (ffca_pkg::IDX_W),
    .DW (2 * ffca_pkg::LEN_W)
  ) u_ext_ram (
    .clk   (clk),
    .we    (ext_req.we),
    .waddr (ext_req.waddr),
    .wdata (ext_req.wdata),
    .raddr (ext_req.raddr),
    .rdata (ext_rdata)
  );

  // block length headers, one per heap word
  ffca_ram #(
    .AW (ffca_pkg::ADDR_W),
    .DW (ffca_pkg::LEN_W)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (hdr_req.we),
    .waddr (hdr_req.waddr),
    .wdata (hdr_req.wdata),
    .raddr (hdr_req.raddr),
    .rdata (hdr_rdata)
  );

  // output stage: load on sequencer transfer, drop on downstream transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* verif/ffca_checker.sv */
// ffca_checker: watches the request, result and region-size channels of the allocator core,
// keeps its own free-extent table and header store, and compares every result transfer
// depends on ffca_pkg
module ffca_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  ffca_pkg::in_item_t         in_data,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  ffca_pkg::out_item_t        out_data,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [ffca_pkg::LEN_W-1:0] cfg_data,
  output int                         fail_count,
  output int                         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WORD_BYTES = 8;

  logic [ffca_pkg::LEN_W-1:0] hdr_len [ffca_pkg::WORDS];
  int                         ext_lo  [ffca_pkg::MAX_EXTENTS];
  int                         ext_hi  [ffca_pkg::MAX_EXTENTS];
  int                         n_ext;
  int                         heap_words;
  ffca_pkg::out_item_t        expected_q [$];

  function automatic int hdr_read(int idx);
    return (idx < ffca_pkg::WORDS) ? int'(hdr_len[idx]) : 0;
  endfunction

  function automatic void drop_extent(int i);
    for (int k = i; k + 1 < n_ext; k++) begin
      ext_lo[k] = ext_lo[k+1];
      ext_hi[k] = ext_hi[k+1];
    end
    n_ext--;
  endfunction

  function automatic void release_block(int addr);
    int lo, len, hi, i;
    bit left, right;
    if (addr == 0) return;
    lo  = addr - 1;
    len = hdr_read(lo);
    if (len == 0) return;
    hi = lo + len;
    if (hi > heap_words) return;
    for (i = 0; i < n_ext; i++) begin
      if (hi <= ext_lo[i]) break;
      if (hi <= ext_hi[i]) return;
    end
    if (i > 0 && lo < ext_hi[i-1]) return;
    left  = (i > 0) && (ext_hi[i-1] == lo);
    right = (i < n_ext) && (ext_lo[i] == hi);
    if (left && right) begin
      ext_hi[i-1] = ext_hi[i];
      drop_extent(i);
    end else if (left) begin
      ext_hi[i-1] = hi;
    end else if (right) begin
      ext_lo[i] = lo;
    end else begin
      if (n_ext >= ffca_pkg::MAX_EXTENTS) return;
      for (int k = n_ext; k > i; k--) begin
        ext_lo[k] = ext_lo[k-1];
        ext_hi[k] = ext_hi[k-1];
      end
      ext_lo[i] = lo;
      ext_hi[i] = hi;
      n_ext++;
    end
  endfunction

  function automatic int take_block(int w);
    int need, i, s, e;
    if (w < ffca_pkg::NODE_WORDS - 1) w = ffca_pkg::NODE_WORDS - 1;
    need = w + 1;
    for (i = 0; i < n_ext; i++) begin
      if (ext_hi[i] >= ext_lo[i] && ext_hi[i] - ext_lo[i] >= need) break;
    end
    if (i >= n_ext) return 0;
    s = ext_lo[i];
    e = ext_hi[i];
    if (s >= ffca_pkg::WORDS) return 0;
    if (e - s - need >= ffca_pkg::NODE_WORDS) begin
      hdr_len[s] = ffca_pkg::LEN_W'(need);
      ext_lo[i]  = s + need;
    end else begin
      hdr_len[s] = ffca_pkg::LEN_W'(e - s);
      drop_extent(i);
    end
    return s + 1;
  endfunction

  function automatic ffca_pkg::out_item_t serve_request(ffca_pkg::in_item_t req);
    int w, addr, total;
    bit failed;
    ffca_pkg::out_item_t res;
    w      = (int'(req.size_bytes) + WORD_BYTES - 1) / WORD_BYTES;
    addr   = 0;
    failed = 0;
    if (w == 0) begin
      release_block(int'(req.old_address));
    end else if (req.old_address == 0) begin
      addr   = take_block(w);
      failed = (addr == 0);
    end else begin
      total = hdr_read(int'(req.old_address) - 1);
      if (total >= 1 && w == total - 1) begin
        addr = int'(req.old_address);
      end else begin
        release_block(int'(req.old_address));
        addr   = take_block(w);
        failed = (addr == 0);
      end
    end
    res.new_address    = ffca_pkg::ADDR_W'(addr);
    res.alloc_failed   = failed;
    res.fragment_count = ffca_pkg::CNT_W'(n_ext);
    return res;
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
    n_ext      = 0;
    heap_words = 0;
    foreach (hdr_len[i]) hdr_len[i] = '0;
  end

  always @(posedge clk) begin
    ffca_pkg::out_item_t want;
    int v;
    if (!rst_n) begin
      n_ext      = 0;
      heap_words = 0;
      expected_q.delete();
    end else begin
      // result first: a result can never belong to a request taken on the same edge
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result transfer with nothing expected: %p", $realtime, out_data);
        end else begin
          want = expected_q.pop_front();
          if (out_data.new_address !== want.new_address ||
              out_data.alloc_failed !== want.alloc_failed ||
              out_data.fragment_count !== want.fragment_count) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch, expected addr %0d failed %0b frags %0d, got %0d %0b %0d",
                       $realtime, want.new_address, want.alloc_failed, want.fragment_count,
                       out_data.new_address, out_data.alloc_failed, out_data.fragment_count);
          end
        end
      end
      if (in_valid && !in_stall) expected_q.push_back(serve_request(in_data));
      if (cfg_valid && cfg_ready) begin
        v = int'(cfg_data);
        if (v > ffca_pkg::WORDS) v = ffca_pkg::WORDS;
        heap_words = v;
        if (v == 0) begin
          n_ext = 0;
        end else begin
          ext_lo[0] = 0;
          ext_hi[0] = v;
          n_ext     = 1;
        end
      end
    end
    pending <= expected_q.size();
  end

endmodule

/* verif/first_fit_coalescing_allocator_core_tb.sv */
// first_fit_coalescing_allocator_core_tb: request stimulus, region-size writes and verdict
// depends on ffca_pkg, ffca_checker and first_fit_coalescing_allocator_core
module first_fit_coalescing_allocator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  ffca_pkg::in_item_t         in_data;
  logic                       out_valid;
  logic                       out_stall;
  ffca_pkg::out_item_t        out_data;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [ffca_pkg::LEN_W-1:0] cfg_data;
  int                         fail_count;
  int                         pending;

  // quiet: no idling on either side in the closing part of the run
  bit               quiet;
  // addresses ever returned by the block; their headers are written, so they are safe to reuse
  int               live_addr [$];
  int               bytes_of  [int];
  int               sent_bytes [$];

  first_fit_coalescing_allocator_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  ffca_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // timeout: worst case is a full extent scan and shift per request plus full stall bursts
  initial begin
    #1_000_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // remember every returned address with the byte size that produced it
  always @(posedge clk) begin
    int b;
    int na;
    if (rst_n && out_valid && !out_stall && sent_bytes.size() > 0) begin
      b  = sent_bytes.pop_front();
      na = int'(out_data.new_address);
      if (na != 0) begin
        if (!bytes_of.exists(na)) live_addr.push_back(na);
        bytes_of[na] = b;
      end
    end
  end

  // result side back-pressure: alternating random bursts of stall and no stall
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 18)) @(negedge clk);
        out_stall = 1'b0;
      end else begin
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end
    end
  end

  // one request transfer; valid is held until the block takes it
  task automatic send_req(int old_a, int nbytes);
    if (!quiet && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 18)) @(negedge clk);
    in_valid            = 1'b1;
    in_data.old_address = ffca_pkg::ADDR_W'(old_a);
    in_data.size_bytes  = ffca_pkg::BYTES_W'(nbytes);
    do @(posedge clk); while (in_stall);
    sent_bytes.push_back(nbytes);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // hold off until every expected result has been seen
  task automatic drain();
    while (pending != 0 || sent_bytes.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // region size write, only issued with the block idle
  task automatic set_region(int words);
    drain();
    cfg_valid = 1'b1;
    cfg_data  = ffca_pkg::LEN_W'(words);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic int pick_addr();
    return (live_addr.size() == 0) ? 0 : live_addr[$urandom_range(0, live_addr.size() - 1)];
  endfunction

  task automatic random_phase(int n_items);
    int r, a;
    for (int n = 0; n < n_items; n++) begin
      r = $urandom_range(0, 99);
      if (n == n_items / 2) drain();
      if (r < 45) begin
        // mostly small blocks, some medium, a few huge that cannot fit
        if ($urandom_range(0, 19) == 0) send_req(0, $urandom_range(0, 20'hFFFFF));
        else if ($urandom_range(0, 4) == 0) send_req(0, $urandom_range(1, 600));
        else send_req(0, $urandom_range(1, 64));
      end else if (r < 75) begin
        send_req(pick_addr(), 0);
      end else if (r < 88) begin
        a = pick_addr();
        if (a != 0 && $urandom_range(0, 1)) send_req(a, bytes_of[a]);
        else send_req(a, $urandom_range(1, 300));
      end else if (r < 93) begin
        send_req(0, 0);
      end else begin
        send_req(pick_addr(), $urandom_range(0, 20'hFFFFF));
      end
    end
  endtask

  initial begin
    int a0, a1, a2, a3, b;
    quiet     = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // no region yet: every allocation fails
    send_req(0, 8);
    set_region(4096);
    // rounding, minimum body, a free of nothing and the largest size
    send_req(0, 1);
    send_req(0, 24);
    send_req(0, 9);
    send_req(0, 40);
    send_req(0, 0);
    send_req(0, 20'hFFFFF);
    drain();
    a0 = live_addr[0]; a1 = live_addr[1]; a2 = live_addr[2]; a3 = live_addr[3];
    send_req(a1, 24);        // unchanged size keeps the address
    send_req(a1, 0);         // isolated free, new extent
    send_req(a1, 0);         // double free is ignored
    send_req(a0, 0);         // merges right
    send_req(a3, 0);         // merges with the tail
    send_req(a2, 0);         // merges on both sides
    send_req(a0, 20'hFFFFF); // resize that fails
    // small heap: fill it, then free a block beyond the last extent
    set_region(64);
    send_req(0, 200);
    send_req(0, 200);
    send_req(0, 200);
    send_req(0, 88);
    drain();
    send_req(live_addr[live_addr.size() - 1], 0);
    set_region(0);
    send_req(0, 16);

    set_region(4096);
    random_phase(500);
    set_region(8191);        // saturates to the full heap
    random_phase(450);
    b = $urandom_range(64, 4095);
    set_region(b);
    random_phase(450);
    set_region(200);
    random_phase(200);
    quiet = 1'b1;
    set_region(4096);
    random_phase(230);

    drain();
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
